### rtl/core/ffud_pkg.sv
// Shared types, character constants and a helper function for the form field decoder.
package ffud_pkg;

    localparam int MAX_KEY_CHARS = 22;
    localparam int HIST_DEPTH    = MAX_KEY_CHARS + 2;
    localparam int RES_SLOTS     = 4;
    localparam int CFG_DATA_W    = 64;
    localparam int KEY_HIGH_W    = 48;

    typedef logic [7:0] t_byte;
    typedef logic [4:0] t_klen;
    typedef logic [1:0] t_pend;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_DECODE = 2'd1,
        PH_SKIP   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_VALUE   = 2'd0,
        KIND_FOUND   = 2'd1,
        KIND_MISSING = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CFG_KEY_LOW     = 3'd0,
        CFG_KEY_MID     = 3'd1,
        CFG_KEY_HIGH    = 3'd2,
        CFG_KEY_LENGTH  = 3'd3,
        CFG_VALUE_LIMIT = 3'd4
    } t_cfg_reg;

    localparam t_pend PEND_NONE    = 2'd0;
    localparam t_pend PEND_PERCENT = 2'd1;
    localparam t_pend PEND_DIGIT   = 2'd2;

    localparam t_byte CHAR_AMP     = 8'h26;
    localparam t_byte CHAR_PLUS    = 8'h2B;
    localparam t_byte CHAR_PERCENT = 8'h25;
    localparam t_byte CHAR_SPACE   = 8'h20;
    localparam t_byte CHAR_EQUALS  = 8'h3D;
    localparam t_byte CHAR_ZERO    = 8'h30;
    localparam t_byte CHAR_NINE    = 8'h39;
    localparam t_byte CHAR_LOW_A   = 8'h61;
    localparam t_byte CHAR_LOW_F   = 8'h66;
    localparam t_byte CHAR_UP_A    = 8'h41;
    localparam t_byte CHAR_UP_F    = 8'h46;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // An invalid character decodes with a zero value.
    function automatic t_hex hex_decode(t_byte c);
        t_hex  r;
        t_byte d;
        r = '0;
        d = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d     = c - CHAR_ZERO;
            r.ok  = 1'b1;
            r.val = d[3:0];
        end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
            d     = c - CHAR_LOW_A + 8'd10;
            r.ok  = 1'b1;
            r.val = d[3:0];
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            d     = c - CHAR_UP_A + 8'd10;
            r.ok  = 1'b1;
            r.val = d[3:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/ffud_if.sv
// Channel interfaces for body bytes, decoded results and configuration writes.
interface ffud_body_if import ffud_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte body_byte;
    logic  body_last;

    modport source (output valid, output body_byte, output body_last, input ready);
    modport sink (input valid, input body_byte, input body_last, output ready);
endinterface

interface ffud_res_if import ffud_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte out_byte;
    t_kind out_kind;
    logic  run_last;

    modport source (output valid, output out_byte, output out_kind, output run_last,
                    input ready);
    modport sink (input valid, input out_byte, input out_kind, input run_last,
                  output ready);
endinterface

interface ffud_cfg_if import ffud_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

### rtl/core/form_field_url_decoder.sv
// Top level of the streaming decoder that extracts one urlencoded form field.
//
//  channel  | dir | payload                          | request taken when
//  ---------+-----+----------------------------------+--------------------
//  i_body   | in  | body_byte, body_last             | valid && ready
//  o_res    | out | out_byte, out_kind, run_last     | valid && ready
//  i_cfg    | in  | reg_index, wr_data               | valid (ready is 1)
//
// A body request is registered in the input register, then decoded into a buffer of up to four
// results, from which its first result is presented.
// The result buffer drains one result per cycle while o_res is ready; a request that makes
// more than one result keeps the body channel stalled until its last result is taken, so the
// rate is one request per cycle while each request makes at most one result and o_res is ready.
// A stall on o_res holds the buffer and, through it, the input register.
// Reset is synchronous and returns the configuration and body state at once.
module form_field_url_decoder import ffud_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffud_body_if.sink  i_body,
    ffud_res_if.source o_res,
    ffud_cfg_if.sink   i_cfg
);

    logic [CFG_DATA_W-1:0] r_key_low, n_key_low;
    logic [CFG_DATA_W-1:0] r_key_mid, n_key_mid;
    logic [KEY_HIGH_W-1:0] r_key_high, n_key_high;
    t_klen                 r_key_len, n_key_len;
    t_byte                 r_limit, n_limit;

    t_byte w_key_arr [MAX_KEY_CHARS];
    t_klen w_kcap;
    t_klen n_klen, r_klen;
    t_byte n_kpat [MAX_KEY_CHARS];
    t_byte r_kpat [MAX_KEY_CHARS];

    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_last;

    t_byte  r_hist [HIST_DEPTH];
    t_klen  r_seen;
    t_phase r_phase;
    logic   r_found;
    t_pend  r_pc;
    t_byte  r_pd;
    t_byte  r_emitted;

    t_byte      r_res_byte [RES_SLOTS];
    t_kind      r_res_kind [RES_SLOTS];
    logic [2:0] r_cnt;
    logic [1:0] r_head;

    logic   w_pop, w_free, w_proc;
    logic   w_zero, w_end, w_search, w_decode, w_amp;
    t_klen  w_seen_inc;
    logic   w_key_ok, w_hit, w_start;
    t_hex   w_hex, w_pend_hex;
    logic   w_flush, w_hold, w_comb, w_plain;
    t_phase s_phase;
    logic   s_found;
    t_pend  s_pc;
    t_byte  s_pd;
    t_byte  w_cand [RES_SLOTS];
    logic [2:0] w_ncand;
    t_byte  w_room;
    logic [2:0] w_kept;
    t_byte  w_res_byte [RES_SLOTS];
    t_kind  w_res_kind [RES_SLOTS];
    logic [2:0] w_nres;

    // Configuration registers and the right-aligned key pattern derived from them.
    always_comb begin
        n_key_low  = r_key_low;
        n_key_mid  = r_key_mid;
        n_key_high = r_key_high;
        n_key_len  = r_key_len;
        n_limit    = r_limit;
        if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_KEY_LOW:     n_key_low  = i_cfg.wr_data;
                CFG_KEY_MID:     n_key_mid  = i_cfg.wr_data;
                CFG_KEY_HIGH:    n_key_high = i_cfg.wr_data[KEY_HIGH_W-1:0];
                CFG_KEY_LENGTH:  n_key_len  = i_cfg.wr_data[4:0];
                CFG_VALUE_LIMIT: n_limit    = i_cfg.wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_key_arr[i]     = n_key_low[8*i +: 8];
            w_key_arr[i + 8] = n_key_mid[8*i +: 8];
        end
        for (int i = 0; i < MAX_KEY_CHARS - 16; i++) begin
            w_key_arr[i + 16] = n_key_high[8*i +: 8];
        end
    end

    assign w_kcap = (n_key_len > t_klen'(MAX_KEY_CHARS)) ? t_klen'(MAX_KEY_CHARS) : n_key_len;

    // The key ends before its first zero character.
    always_comb begin
        n_klen = w_kcap;
        for (int i = MAX_KEY_CHARS - 1; i >= 0; i--) begin
            if (t_klen'(i) < w_kcap && w_key_arr[i] == '0) begin
                n_klen = t_klen'(i);
            end
        end
    end

    always_comb begin
        t_klen v_idx;
        v_idx = '0;
        for (int j = 0; j < MAX_KEY_CHARS; j++) begin
            v_idx     = n_klen - t_klen'(1) - t_klen'(j);
            n_kpat[j] = '0;
            if (t_klen'(j) < n_klen && v_idx < t_klen'(MAX_KEY_CHARS)) begin
                n_kpat[j] = w_key_arr[v_idx];
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    // Handshake between the input register and the result buffer.
    assign w_pop        = o_res.valid && o_res.ready;
    assign w_free       = (r_cnt == 3'd0) || (r_cnt == 3'd1 && w_pop);
    assign w_proc       = r_in_valid && w_free;
    assign i_body.ready = !r_in_valid || w_proc;

    // Byte classification.
    assign w_zero     = (r_in_byte == '0);
    assign w_end      = w_zero || r_in_last;
    assign w_search   = !w_zero && r_phase == PH_SEARCH;
    assign w_decode   = !w_zero && r_phase == PH_DECODE;
    assign w_amp      = (r_in_byte == CHAR_AMP);
    assign w_seen_inc = (r_seen == t_klen'(HIST_DEPTH)) ? r_seen : r_seen + t_klen'(1);

    always_comb begin
        w_key_ok = 1'b1;
        for (int j = 0; j < MAX_KEY_CHARS; j++) begin
            if (t_klen'(j) < r_klen && r_hist[j] != r_kpat[j]) begin
                w_key_ok = 1'b0;
            end
        end
    end

    assign w_hit   = w_search && r_in_byte == CHAR_EQUALS && w_seen_inc > r_klen && w_key_ok;
    assign w_start = (w_seen_inc == r_klen + t_klen'(1)) || (r_hist[r_klen] == CHAR_AMP);

    assign w_hex      = hex_decode(r_in_byte);
    assign w_pend_hex = hex_decode(r_pd);
    assign w_flush    = w_decode && (w_amp || (r_pc != PEND_NONE && !w_hex.ok));
    assign w_hold     = w_decode && r_pc == PEND_PERCENT && w_hex.ok;
    assign w_comb     = w_decode && r_pc == PEND_DIGIT && w_hex.ok;
    assign w_plain    = w_decode && !w_amp && (r_pc == PEND_NONE || !w_hex.ok);

    // Next state of the field search and the escape decoder.
    always_comb begin
        s_phase = r_phase;
        s_found = r_found;
        s_pc    = r_pc;
        s_pd    = r_pd;
        if (w_hit) begin
            s_phase = w_start ? PH_DECODE : PH_SKIP;
            s_found = r_found || w_start;
        end
        if (w_decode) begin
            if (w_amp) begin
                s_phase = PH_SKIP;
            end
            if (w_hold) begin
                s_pc = PEND_DIGIT;
            end else if (w_plain && r_in_byte == CHAR_PERCENT) begin
                s_pc = PEND_PERCENT;
            end else begin
                s_pc = PEND_NONE;
            end
            s_pd = w_hold ? r_in_byte : '0;
        end
    end

    // Candidate value bytes in order, then the limit and the end result.
    always_comb begin
        for (int i = 0; i < RES_SLOTS; i++) begin
            w_cand[i] = '0;
        end
        w_ncand = '0;
        if (w_flush && r_pc != PEND_NONE) begin
            w_cand[w_ncand[1:0]] = CHAR_PERCENT;
            w_ncand              = w_ncand + 3'd1;
        end
        if (w_flush && r_pc == PEND_DIGIT) begin
            w_cand[w_ncand[1:0]] = r_pd;
            w_ncand              = w_ncand + 3'd1;
        end
        if (w_comb) begin
            w_cand[w_ncand[1:0]] = {w_pend_hex.val, w_hex.val};
            w_ncand              = w_ncand + 3'd1;
        end
        if (w_plain && r_in_byte != CHAR_PERCENT) begin
            w_cand[w_ncand[1:0]] = (r_in_byte == CHAR_PLUS) ? CHAR_SPACE : r_in_byte;
            w_ncand              = w_ncand + 3'd1;
        end
        if (w_end && s_pc != PEND_NONE) begin
            w_cand[w_ncand[1:0]] = CHAR_PERCENT;
            w_ncand              = w_ncand + 3'd1;
        end
        if (w_end && s_pc == PEND_DIGIT) begin
            w_cand[w_ncand[1:0]] = s_pd;
            w_ncand              = w_ncand + 3'd1;
        end
    end

    assign w_room = (r_emitted < r_limit) ? r_limit - r_emitted : '0;
    assign w_kept = (w_room >= {5'b0, w_ncand}) ? w_ncand : w_room[2:0];
    assign w_nres = w_kept + {2'b0, w_end};

    always_comb begin
        for (int i = 0; i < RES_SLOTS; i++) begin
            w_res_byte[i] = '0;
            w_res_kind[i] = KIND_VALUE;
            if (3'(i) < w_kept) begin
                w_res_byte[i] = w_cand[i];
            end else if (3'(i) == w_kept && w_end) begin
                w_res_kind[i] = s_found ? KIND_FOUND : KIND_MISSING;
            end
        end
    end

    assign o_res.valid    = (r_cnt != 3'd0);
    assign o_res.out_byte = r_res_byte[r_head];
    assign o_res.out_kind = r_res_kind[r_head];
    assign o_res.run_last = (r_cnt == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_mid  <= '0;
            r_key_high <= '0;
            r_key_len  <= t_klen'(1);
            r_limit    <= t_byte'(63);
            r_klen     <= '0;
            for (int j = 0; j < MAX_KEY_CHARS; j++) begin
                r_kpat[j] <= '0;
            end
        end else begin
            r_key_low  <= n_key_low;
            r_key_mid  <= n_key_mid;
            r_key_high <= n_key_high;
            r_key_len  <= n_key_len;
            r_limit    <= n_limit;
            r_klen     <= n_klen;
            r_kpat     <= n_kpat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_body.ready) begin
            r_in_valid <= i_body.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_body.ready && i_body.valid) begin
            r_in_byte <= i_body.body_byte;
            r_in_last <= i_body.body_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_seen    <= '0;
            r_phase   <= PH_SEARCH;
            r_found   <= 1'b0;
            r_pc      <= PEND_NONE;
            r_pd      <= '0;
            r_emitted <= '0;
        end else if (w_proc) begin
            if (w_end) begin
                for (int i = 0; i < HIST_DEPTH; i++) begin
                    r_hist[i] <= '0;
                end
                r_seen    <= '0;
                r_phase   <= PH_SEARCH;
                r_found   <= 1'b0;
                r_pc      <= PEND_NONE;
                r_pd      <= '0;
                r_emitted <= '0;
            end else begin
                if (w_search) begin
                    r_hist[0] <= r_in_byte;
                    for (int i = 1; i < HIST_DEPTH; i++) begin
                        r_hist[i] <= r_hist[i-1];
                    end
                    r_seen <= w_seen_inc;
                end
                r_phase   <= s_phase;
                r_found   <= s_found;
                r_pc      <= s_pc;
                r_pd      <= s_pd;
                r_emitted <= r_emitted + t_byte'(w_kept);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_head <= '0;
        end else if (w_proc) begin
            r_cnt  <= w_nres;
            r_head <= '0;
        end else if (w_pop) begin
            r_cnt  <= r_cnt - 3'd1;
            r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_res_byte <= w_res_byte;
            r_res_kind <= w_res_kind;
        end
    end

endmodule

### rtl/core/ffud_checker.sv
// Port-level assertions for the form field decoder and the bind that attaches them.
module ffud_checker import ffud_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_res_valid,
    input logic  i_res_ready,
    input t_byte i_res_byte,
    input t_kind i_res_kind,
    input logic  i_res_last
);

    // A stalled result holds its payload.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_byte)
            && $stable(i_res_kind) && $stable(i_res_last))
        else $error("result changed while stalled");

    // An end result carries a zero byte.
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_kind != KIND_VALUE |-> i_res_byte == '0)
        else $error("end result with a nonzero byte");

    // An end result always closes the run of its request.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_kind != KIND_VALUE |-> i_res_last)
        else $error("end result not marked last");

    // A run that is not finished continues in the next cycle.
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && !i_res_last |=> i_res_valid)
        else $error("run of results broken off");

endmodule

bind form_field_url_decoder ffud_checker u_ffud_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_byte  (o_res.out_byte),
    .i_res_kind  (o_res.out_kind),
    .i_res_last  (o_res.run_last)
);
